// File: rtl/core/ndc_pkg.sv
package ndc_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 5;

  // config register map (index = paddr[3:2])
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_OPEN_CHAR  = 2'd0;
  localparam logic [1:0] REG_CLOSE_CHAR = 2'd1;
  localparam logic [1:0] REG_CORE_CHAR  = 2'd2;

  localparam logic [7:0] OPEN_CHAR_RST  = 8'd91;
  localparam logic [7:0] CLOSE_CHAR_RST = 8'd93;
  localparam logic [7:0] CORE_CHAR_RST  = 8'd126;

  typedef enum logic [1:0] {
    TOK_OPEN   = 2'd0,
    TOK_CDELIM = 2'd1,
    TOK_CORE   = 2'd2
  } tok_t;

  typedef enum logic [2:0] {
    CLS_PAD      = 3'd0,
    CLS_CDELIM   = 3'd1,
    CLS_PREFIX   = 3'd2,
    CLS_CORETEXT = 3'd3,
    CLS_POSTFIX  = 3'd4,
    CLS_PLAIN    = 3'd5
  } cls_t;

  // per-cell move
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_DOWN,  // take from the cell nearer the top (push)
    CELL_SHIFT_UP     // take from the cell further down (pop)
  } cell_op_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic replace;
    tok_t tok;
  } stack_cmd_t;

  typedef struct packed {
    logic [7:0] open_char;
    logic [7:0] close_char;
    logic [7:0] core_char;
  } cfg_t;

  // packs straight into the low bits of out_tdata
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               ovf;
    cls_t               cls;
  } result_t;

endpackage

// File: rtl/core/ndc_cell.sv
module ndc_cell (
  input  logic             clk,
  input  ndc_pkg::cell_op_t op,
  input  ndc_pkg::tok_t    from_up,
  input  ndc_pkg::tok_t    from_down,
  output ndc_pkg::tok_t    tok
);
  import ndc_pkg::*;

  tok_t tok_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_SHIFT_DOWN: tok_r <= from_up;
      CELL_SHIFT_UP:   tok_r <= from_down;
      default:         tok_r <= tok_r;
    endcase
  end

  assign tok = tok_r;

endmodule

// File: rtl/core/ndc_ctrl.sv
module ndc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  ndc_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char,
  input  ndc_pkg::tok_t       top_tok,
  output ndc_pkg::stack_cmd_t cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output ndc_pkg::result_t    out_res
);
  import ndc_pkg::*;

  typedef enum logic {ST_IDLE, ST_POP} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] open_cnt_r, open_cnt_nxt;
  logic             out_v_r, hold_v_r;
  result_t          out_res_r, hold_res_r;

  logic             accept;
  logic             has_room;
  logic             res_fire;
  result_t          res;

  assign in_ready = (state_r == ST_IDLE) && !hold_v_r;
  assign accept   = in_valid && in_ready;
  assign has_room = cnt_r < CNT_W'(STACK_DEPTH);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    open_cnt_nxt = open_cnt_r;
    cmd          = '0;
    cmd.tok      = TOK_OPEN;
    res_fire     = 1'b0;
    res          = '0;
    res.cls      = CLS_PLAIN;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_fire = 1'b1;
          if (in_char == cfg.open_char) begin
            res.cls = CLS_PAD;
            if (has_room) begin
              cmd.push     = 1'b1;
              cmd.tok      = TOK_OPEN;
              cnt_nxt      = cnt_r + CNT_W'(1);
              open_cnt_nxt = open_cnt_r + CNT_W'(1);
            end else begin
              res.ovf = 1'b1;
            end
          end else if (in_char == cfg.close_char) begin
            res.cls = CLS_PAD;
            // unwind one token a cycle down to the open-pad
            if (open_cnt_r != '0) begin
              res_fire  = 1'b0;
              state_nxt = ST_POP;
            end
          end else if (in_char == cfg.core_char) begin
            res.cls = CLS_CDELIM;
            if (cnt_r != '0 && top_tok == TOK_CDELIM) begin
              cmd.replace = 1'b1;
              cmd.tok     = TOK_CORE;
            end else if (has_room) begin
              cmd.push = 1'b1;
              cmd.tok  = TOK_CDELIM;
              cnt_nxt  = cnt_r + CNT_W'(1);
            end else begin
              res.ovf = 1'b1;
            end
          end else if (cnt_r == '0) begin
            res.cls = CLS_PLAIN;
          end else begin
            case (top_tok)
              TOK_OPEN:   res.cls = CLS_PREFIX;
              TOK_CDELIM: res.cls = CLS_CORETEXT;
              TOK_CORE:   res.cls = CLS_POSTFIX;
              default:    res.cls = CLS_PLAIN;
            endcase
          end
        end
      end
      ST_POP: begin
        cmd.pop = 1'b1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (top_tok == TOK_OPEN) begin
          open_cnt_nxt = open_cnt_r - CNT_W'(1);
          res_fire     = 1'b1;
          res.cls      = CLS_PAD;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    res.depth = DEPTH_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      open_cnt_r <= '0;
      out_v_r    <= 1'b0;
      hold_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      open_cnt_r <= open_cnt_nxt;
      if (res_fire) begin
        if (out_v_r && !out_ready) begin
          hold_res_r <= res;
          hold_v_r   <= 1'b1;
        end else begin
          out_res_r <= res;
          out_v_r   <= 1'b1;
        end
      end else if (out_v_r && out_ready) begin
        if (hold_v_r) begin
          out_res_r <= hold_res_r;
          hold_v_r  <= 1'b0;
        end else begin
          out_v_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/core/nested_delimiter_classifier_unit.sv
// Nested delimiter classifier.
// Input channel (in_*): one text character per transaction in in_tdata[7:0].
// Output channel (out_*): one classification per input transaction, in order:
//   out_tdata[2:0] char class, [3] overflow, [8:4] stack depth, [15:9] zero.
// Config (cfg_*): APB-style, pready tied high. Byte address 0 open char,
//   4 close char, 8 core char (low 8 bits of the word). Write only while idle.
// Timing: the result is registered in the output slot, or in the hold slot
//   while out_tready is low. A close char with an open-pad on the stack
//   unwinds the token stack one token per cycle through the cell chain and
//   takes no new input meanwhile. All other characters: one item per cycle
//   while the output is not stalled.
// The stack is a chain of 16 cells, top at cell 0; pushes shift the chain
//   down, pops shift it up. Count and open-pad count sit in the controller.
// Reset (rst_n, sync, active low) empties the stack, restores the default
//   characters and drops any result in flight.
// Output stall: a second result slot lets one more transaction be taken
//   while out_tready is low; after that in_tready drops until space frees.
module nested_delimiter_classifier_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] char_code
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [2:0] char_class, [3] overflow,
                                                  // [8:4] depth, [15:9] zero
  // config port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ndc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import ndc_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  stack_cmd_t cmd;
  tok_t       cell_tok [STACK_DEPTH];
  result_t    out_res;

  // ---------------- config registers ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_char  <= OPEN_CHAR_RST;
      cfg_r.close_char <= CLOSE_CHAR_RST;
      cfg_r.core_char  <= CORE_CHAR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OPEN_CHAR:  cfg_r.open_char  <= cfg_pwdata[7:0];
        REG_CLOSE_CHAR: cfg_r.close_char <= cfg_pwdata[7:0];
        REG_CORE_CHAR:  cfg_r.core_char  <= cfg_pwdata[7:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OPEN_CHAR:  cfg_prdata = {24'd0, cfg_r.open_char};
      REG_CLOSE_CHAR: cfg_prdata = {24'd0, cfg_r.close_char};
      REG_CORE_CHAR:  cfg_prdata = {24'd0, cfg_r.core_char};
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- controller ----------------
  ndc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .top_tok   (cell_tok[0]),
    .cmd       (cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {7'd0, out_res};

  // ---------------- token stack: chain of cells ----------------
  // Entries at or beyond the count hold stale tokens; they are never read.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    tok_t     from_up;
    tok_t     from_down;
    cell_op_t op;

    if (i == 0) begin : g_top
      assign from_up = cmd.tok;
      assign op = (cmd.push || cmd.replace) ? CELL_SHIFT_DOWN :
                  cmd.pop ? CELL_SHIFT_UP : CELL_HOLD;
    end else begin : g_mid
      assign from_up = cell_tok[i-1];
      assign op = cmd.push ? CELL_SHIFT_DOWN :
                  cmd.pop  ? CELL_SHIFT_UP : CELL_HOLD;
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign from_down = cell_tok[i];
    end else begin : g_link
      assign from_down = cell_tok[i+1];
    end

    ndc_cell u_cell (
      .clk       (clk),
      .op        (op),
      .from_up   (from_up),
      .from_down (from_down),
      .tok       (cell_tok[i])
    );
  end

endmodule

// File: rtl/core/ndc_checker.sv
module ndc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [15:0]                out_tdata
);
  import ndc_pkg::*;

  logic [2:0]         cls;
  logic               ovf;
  logic [DEPTH_W-1:0] depth;

  assign cls   = out_tdata[2:0];
  assign ovf   = out_tdata[3];
  assign depth = out_tdata[8:4];

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> depth <= DEPTH_W'(STACK_DEPTH))
    else $error("depth beyond stack size");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ovf |-> depth == DEPTH_W'(STACK_DEPTH) &&
      (cls == CLS_PAD || cls == CLS_CDELIM))
    else $error("overflow without full stack or push char");

  a_plain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cls == CLS_PLAIN |-> depth == '0 && !ovf)
    else $error("plain class with tokens on stack");

endmodule

bind nested_delimiter_classifier_unit ndc_checker u_ndc_checker (.*);
